[design/mlfq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants
// Item, configuration and state types of the multilevel feedback queue block.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int LEVEL_COUNT_DEFAULT = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_BITS_DEFAULT     = 8;

   localparam logic [15:0] QUANTUM_ZERO_RESET = 16'd20;
   localparam logic [15:0] QUANTUM_ONE_RESET  = 16'd40;
   localparam logic [15:0] QUANTUM_TWO_RESET  = 16'd80;
   localparam logic [7:0]  TICK_MS_RESET      = 8'd10;

   localparam logic [1:0] CSR_QUANTUM_ZERO = 2'd0;
   localparam logic [1:0] CSR_QUANTUM_ONE  = 2'd1;
   localparam logic [1:0] CSR_QUANTUM_TWO  = 2'd2;
   localparam logic [1:0] CSR_TICK_MS      = 2'd3;

   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_ARRIVAL = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  task_id;
      logic [15:0] task_length;
      logic [31:0] now_ms;
   } mlfq_item_type;

   typedef struct packed {
      logic [15:0] quantum_zero;
      logic [15:0] quantum_one;
      logic [15:0] quantum_two;
      logic [7:0]  tick_ms;
   } mlfq_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PICK,
      ST_LOAD,
      ST_REPLY
   } mlfq_state_type;

endpackage

`default_nettype wire

[design/mlfq_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_front: input stage
// Accepts items from the request channel into a two-entry queue that feeds
// the scheduler core.
// ----------------------------------------------------------------------------
module mlfq_front
   import mlfq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire mlfq_item_type req_item,
   output logic               item_valid,
   input  wire logic          item_ready,
   output mlfq_item_type      item_data
);

   mlfq_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push, pop;

   assign req_ready  = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item_data  = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("front queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |=> (count_ff <= 2'd1)) else $error("front queue jumped");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2))
      else $error("front queue lost an item");

endmodule

`default_nettype wire

[design/mlfq_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_back: scheduler core
// Runs arrivals and ticks against the level FIFOs, which share one memory,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module mlfq_back
   import mlfq_pkg::*;
#(
   parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = ID_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mlfq_cfg_type  cfg,
   input  wire logic          item_valid,
   output logic               item_ready,
   input  wire mlfq_item_type item_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_done_valid,
   output logic [7:0]         rsp_done_id,
   output logic [31:0]        rsp_done_time,
   output logic               rsp_demoted_valid,
   output logic               rsp_running_valid,
   output logic [7:0]         rsp_running_id,
   output logic [1:0]         rsp_running_level,
   output logic               rsp_arrival_dropped
);

   localparam int LVL_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(LEVEL_COUNT * QUEUE_DEPTH);
   localparam int ENTRY_W = ID_BITS + 32;
   localparam int MEM_DEPTH = LEVEL_COUNT * QUEUE_DEPTH;

   mlfq_state_type state_ff, state_in;

   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [PTR_W-1:0] head_ff [LEVEL_COUNT];
   logic [PTR_W-1:0] tail_ff [LEVEL_COUNT];
   logic [CNT_W-1:0] count_ff [LEVEL_COUNT];

   mlfq_item_type    cur_ff;
   logic             run_ff;
   logic [ID_BITS-1:0] run_id_ff;
   logic [ID_BITS-1:0] done_id_ff;
   logic [15:0]      run_len_ff;
   logic [15:0]      run_el_ff;
   logic [LVL_W-1:0] level_ff;
   logic [15:0]      slice_ff;
   logic             done_ff, demoted_ff, dropped_ff;

   logic             out_free;
   logic [16:0]      el_sum, sl_sum;
   logic [15:0]      el_new, sl_new, quantum;
   logic [LVL_W-1:0] next_lvl, pick_lvl;
   logic             pick_found;
   logic             tick_run, finish, expire;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [LVL_W-1:0] wr_lvl;
   logic [15:0]      done_id_wide, run_id_wide;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign out_free = !rsp_valid || rsp_ready;

   always_comb begin
      el_sum = {1'b0, run_el_ff} + 17'(cfg.tick_ms);
      sl_sum = {1'b0, slice_ff} + 17'(cfg.tick_ms);
      el_new = el_sum[16] ? 16'hFFFF : el_sum[15:0];
      sl_new = sl_sum[16] ? 16'hFFFF : sl_sum[15:0];
      if (level_ff == LVL_W'(0)) begin
         quantum = cfg.quantum_zero;
      end else if (level_ff == LVL_W'(1)) begin
         quantum = cfg.quantum_one;
      end else begin
         quantum = cfg.quantum_two;
      end
      tick_run = (cur_ff.mode == MODE_TICK) && run_ff;
      finish   = tick_run && (el_new >= run_len_ff);
      expire   = tick_run && !finish && (sl_new >= quantum);
      next_lvl = (level_ff == LVL_W'(LEVEL_COUNT - 1)) ? level_ff : level_ff + LVL_W'(1);
      pick_found = 1'b0;
      pick_lvl   = '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         if (!pick_found && count_ff[i] != '0) begin
            pick_found = 1'b1;
            pick_lvl   = LVL_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = (cur_ff.mode == MODE_ARRIVAL) ? ST_REPLY : ST_PICK;
         end
         ST_PICK: begin
            state_in = (!run_ff && pick_found) ? ST_LOAD : ST_REPLY;
         end
         ST_LOAD: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      item_ready = 1'b0;
      wr_en      = 1'b0;
      wr_lvl     = '0;
      wr_data    = {run_id_ff, run_len_ff, el_new};
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
         end
         ST_EXEC: begin
            if (cur_ff.mode == MODE_ARRIVAL) begin
               wr_lvl  = '0;
               wr_data = {ID_BITS'(cur_ff.task_id), cur_ff.task_length, 16'd0};
               wr_en   = (count_ff[0] < CNT_W'(QUEUE_DEPTH));
            end else if (expire) begin
               wr_lvl = next_lvl;
               wr_en  = (count_ff[next_lvl] < CNT_W'(QUEUE_DEPTH));
            end
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
      wr_addr = ADDR_W'(wr_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_ff[wr_lvl]);
      rd_addr = ADDR_W'(pick_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[pick_lvl]);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_PICK) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && item_ready) begin
         cur_ff <= item_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         run_ff     <= 1'b0;
         run_id_ff  <= '0;
         done_id_ff <= '0;
         run_len_ff <= '0;
         run_el_ff  <= '0;
         level_ff   <= '0;
         slice_ff   <= '0;
         done_ff    <= 1'b0;
         demoted_ff <= 1'b0;
         dropped_ff <= 1'b0;
         rsp_valid  <= 1'b0;
         for (int i = 0; i < LEVEL_COUNT; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_REPLY && out_free) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (wr_en) begin
            tail_ff[wr_lvl]  <= ptr_next(tail_ff[wr_lvl]);
            count_ff[wr_lvl] <= count_ff[wr_lvl] + CNT_W'(1);
         end
         case (state_ff)
            ST_EXEC: begin
               done_ff    <= finish;
               done_id_ff <= run_id_ff;
               demoted_ff <= expire && wr_en;
               dropped_ff <= (cur_ff.mode == MODE_ARRIVAL) && !wr_en;
               if (tick_run) begin
                  run_el_ff <= el_new;
                  slice_ff  <= (finish || expire) ? '0 : sl_new;
               end
               if (finish || (expire && wr_en)) begin
                  run_ff <= 1'b0;
               end
            end
            ST_PICK: begin
               if (!run_ff && pick_found) begin
                  head_ff[pick_lvl]  <= ptr_next(head_ff[pick_lvl]);
                  count_ff[pick_lvl] <= count_ff[pick_lvl] - CNT_W'(1);
                  level_ff <= pick_lvl;
                  slice_ff <= '0;
               end
            end
            ST_LOAD: begin
               run_ff <= 1'b1;
               {run_id_ff, run_len_ff, run_el_ff} <= rd_data_ff;
            end
            default: begin
               run_ff <= run_ff;
            end
         endcase
      end
   end

   assign done_id_wide = 16'(done_id_ff);
   assign run_id_wide  = 16'(run_id_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_REPLY && out_free) begin
         rsp_done_valid      <= done_ff;
         rsp_done_id         <= done_ff ? done_id_wide[7:0] : 8'd0;
         rsp_done_time       <= done_ff ? cur_ff.now_ms : 32'd0;
         rsp_demoted_valid   <= demoted_ff;
         rsp_running_valid   <= run_ff;
         rsp_running_id      <= run_ff ? run_id_wide[7:0] : 8'd0;
         rsp_running_level   <= run_ff ? 2'(level_ff) : 2'd0;
         rsp_arrival_dropped <= dropped_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CNT_W'(QUEUE_DEPTH)) else $error("level zero count overflow");
   a_load_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> run_ff) else $error("dispatch did not load a task");
   a_reply_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && out_free) |=> rsp_valid) else $error("result not posted");
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cur_ff.mode == MODE_TICK && run_ff && el_new >= run_len_ff)
      |=> (!run_ff && done_ff)) else $error("finished task still running");

endmodule

`default_nettype wire

[design/mlfq_task_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_task_scheduler: three-level multilevel feedback queue scheduler
// Request items are either a scheduler tick (req_mode 0) or a task arrival
// (req_mode 1); each produces exactly one result item on the rsp_ channel.
// Both channels use valid/ready. The csr_ port writes the three quanta and
// tick_ms by index; write only while the block is idle.
// A two-entry input queue decouples the request channel from the core, so
// items are taken while a result waits for the receiver.
// An arrival passes the core states EXEC and REPLY before its result is valid;
// a tick passes EXEC, PICK and REPLY, and LOAD as well when it dispatches,
// which takes the registered read of the level FIFO memory. One item is in
// the core at a time, so the core takes no new item until its result is posted.
// Reset clears all pointers, counts and the running task and restores the
// register defaults; the FIFO memory is not cleared. When rsp_ready is low
// the result holds and the core waits, and the input queue fills up to two.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler
   import mlfq_pkg::*;
#(
   parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ID_BITS     = ID_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_task_id,
   input  wire logic [15:0] req_task_length,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_done_valid,
   output logic [7:0]       rsp_done_id,
   output logic [31:0]      rsp_done_time,
   output logic             rsp_demoted_valid,
   output logic             rsp_running_valid,
   output logic [7:0]       rsp_running_id,
   output logic [1:0]       rsp_running_level,
   output logic             rsp_arrival_dropped
);

   mlfq_cfg_type  cfg_ff;
   mlfq_item_type req_item, item_data;
   logic          item_valid, item_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum_zero <= QUANTUM_ZERO_RESET;
         cfg_ff.quantum_one  <= QUANTUM_ONE_RESET;
         cfg_ff.quantum_two  <= QUANTUM_TWO_RESET;
         cfg_ff.tick_ms      <= TICK_MS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_QUANTUM_ZERO: cfg_ff.quantum_zero <= csr_wdata;
            CSR_QUANTUM_ONE:  cfg_ff.quantum_one  <= csr_wdata;
            CSR_QUANTUM_TWO:  cfg_ff.quantum_two  <= csr_wdata;
            CSR_TICK_MS:      cfg_ff.tick_ms      <= csr_wdata[7:0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   assign req_item = '{mode: req_mode, task_id: req_task_id,
                       task_length: req_task_length, now_ms: req_now_ms};

   mlfq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item_data  (item_data)
   );

   mlfq_back #(
      .LEVEL_COUNT (LEVEL_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .item_valid          (item_valid),
      .item_ready          (item_ready),
      .item_data           (item_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_done_valid      (rsp_done_valid),
      .rsp_done_id         (rsp_done_id),
      .rsp_done_time       (rsp_done_time),
      .rsp_demoted_valid   (rsp_demoted_valid),
      .rsp_running_valid   (rsp_running_valid),
      .rsp_running_id      (rsp_running_id),
      .rsp_running_level   (rsp_running_level),
      .rsp_arrival_dropped (rsp_arrival_dropped)
   );

endmodule

`default_nettype wire
